### sv/csr_pkg.sv
package csr_pkg;

  localparam int unsigned CP_W          = 21;
  localparam int unsigned MAX_CHARS_DEF = 64;

  // combining mark ranges
  localparam logic [CP_W-1:0] MARK_A_LO = CP_W'(32'h0300);
  localparam logic [CP_W-1:0] MARK_A_HI = CP_W'(32'h036F);
  localparam logic [CP_W-1:0] MARK_B_LO = CP_W'(32'h1DC0);
  localparam logic [CP_W-1:0] MARK_B_HI = CP_W'(32'h1DFF);
  localparam logic [CP_W-1:0] MARK_C_LO = CP_W'(32'h20D0);
  localparam logic [CP_W-1:0] MARK_C_HI = CP_W'(32'h20FF);
  localparam logic [CP_W-1:0] MARK_D_LO = CP_W'(32'hFE20);
  localparam logic [CP_W-1:0] MARK_D_HI = CP_W'(32'hFE2F);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  function automatic logic is_mark(input logic [CP_W-1:0] cp);
    is_mark = ((cp >= MARK_A_LO) && (cp <= MARK_A_HI)) ||
              ((cp >= MARK_B_LO) && (cp <= MARK_B_HI)) ||
              ((cp >= MARK_C_LO) && (cp <= MARK_C_HI)) ||
              ((cp >= MARK_D_LO) && (cp <= MARK_D_HI));
  endfunction

endpackage

### sv/combining_aware_string_reverse_top.sv
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+-------------------------------------------
// in      | input     | in_valid_i / in_stall_o   | code_point_i, last_char_i
// out     | output    | out_valid_o / out_stall_i | out_code_point_o, out_last_o, overflow_o
//
// each character that is not last is stored while the buffer has room; the block is ready again next cycle
// on the last character the sequencer walks the buffer through its single read port:
// every stored character is read once for the cluster scan (S_SCAN_RD, S_SCAN_CHK) and once
// for emit (S_EMIT_RD, S_EMIT_OUT), output stalls holding emit, before in_stall_o drops
// rst_ni clears the count, overflow flag, sequencer and output valid; the buffer is not cleared
// out_stall_i holds the output register and emit; a loaded input transaction is kept meanwhile
module combining_aware_string_reverse_top #(
  parameter int unsigned MaxChars = csr_pkg::MAX_CHARS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [csr_pkg::CP_W-1:0]  code_point_i,
  input  logic                      last_char_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [csr_pkg::CP_W-1:0]  out_code_point_o,
  output logic                      out_last_o,
  output logic                      overflow_o
);
  import csr_pkg::*;

  // index width addresses the buffer, count width also holds the full depth
  localparam int unsigned AW = (MaxChars > 1) ? $clog2(MaxChars) : 1;
  localparam int unsigned CW = $clog2(MaxChars + 1);
  localparam int unsigned DW = CP_W + 1;

  // buffer word: mark flag on top of the code point
  logic [DW-1:0] mem [MaxChars];
  logic [DW-1:0] rd_q;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] rem_q, rem_d;      // end (exclusive) of the part not yet emitted
  logic [AW-1:0] start_q, start_d;  // cluster start, walks backwards in scan
  logic [AW-1:0] idx_q, idx_d;      // emit pointer inside the current cluster

  logic                out_valid_q, out_valid_d;
  logic [CP_W-1:0]     out_cp_q, out_cp_d;
  logic                out_last_q, out_last_d;
  logic                out_ovf_q, out_ovf_d;

  logic          in_acc;
  logic          has_room;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          out_free;
  logic          cluster_end;
  logic          string_end;
  logic [CW-1:0] stored_cnt;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign has_room   = (count_q < CW'(MaxChars));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign wr_en   = in_acc && has_room;
  assign wr_addr = count_q[AW-1:0];
  assign wr_data = {is_mark(code_point_i), code_point_i};

  assign rd_en   = (state_q == S_SCAN_RD) || (state_q == S_EMIT_RD);
  assign rd_addr = (state_q == S_SCAN_RD) ? start_q : idx_q;

  // count including the transaction being taken now
  assign stored_cnt  = has_room ? (count_q + CW'(1)) : count_q;
  assign cluster_end = ((CW'(idx_q) + CW'(1)) == rem_q);
  assign string_end  = cluster_end && (start_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && last_char_i) begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if ((start_q != '0) && rd_q[DW-1]) begin
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          if (string_end) begin
            state_d = S_IDLE;
          end else if (cluster_end) begin
            state_d = S_SCAN_RD;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    rem_d       = rem_q;
    start_d     = start_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_cp_d    = out_cp_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          count_d = stored_cnt;
          if (!has_room) begin
            ovf_d = 1'b1;
          end
          if (last_char_i) begin
            // stored_cnt is at least one here
            rem_d   = stored_cnt;
            start_d = AW'(stored_cnt - CW'(1));
          end
        end
      end
      S_SCAN_RD: begin
      end
      S_SCAN_CHK: begin
        if ((start_q != '0) && rd_q[DW-1]) begin
          start_d = start_q - AW'(1);
        end else begin
          idx_d = start_q;
        end
      end
      S_EMIT_RD: begin
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cp_d    = rd_q[CP_W-1:0];
          out_last_d  = string_end;
          out_ovf_d   = ovf_q;
          if (string_end) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else if (cluster_end) begin
            rem_d   = CW'(start_q);
            start_d = start_q - AW'(1);
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pointers and output payload
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    start_q   <= start_d;
    idx_q     <= idx_d;
    out_cp_q  <= out_cp_d;
    out_last_q <= out_last_d;
    out_ovf_q <= out_ovf_d;
  end

  // character buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_code_point_o = out_cp_q;
  assign out_last_o       = out_last_q;
  assign overflow_o       = out_ovf_q;

  // count never runs past the buffer depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxChars))
    else $error("character count exceeds buffer depth");

  // the cluster walk stays inside the unemitted part of the string;
  // the emit pointer is only meaningful once emit of a cluster has begun
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CHK || state_q == S_EMIT_RD || state_q == S_EMIT_OUT)
    |-> (CW'(start_q) < rem_q) && ((state_q == S_SCAN_CHK) || (CW'(idx_q) < rem_q)))
    else $error("cluster pointer outside remaining string");

  // emitting the final character frees the block with cleared string state
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_OUT && out_free && string_end)
    |=> (state_q == S_IDLE) && (count_q == '0) && !ovf_q && out_valid_o && out_last_o)
    else $error("string end did not return to idle");

  // a new string cannot start while the block is walking the buffer
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (count_q == $past(count_q)) || (count_q == '0))
    else $error("buffer count changed during walk");

endmodule

### sim/reversal_checker.sv
`timescale 1ns / 1ps

module reversal_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [csr_pkg::CP_W-1:0]  code_point_i,
  input  logic                      last_char_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [csr_pkg::CP_W-1:0]  out_code_point_i,
  input  logic                      out_last_i,
  input  logic                      overflow_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_o
);

  import csr_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            fin;
    logic            lost;
  } rev_char_t;

  logic [CP_W-1:0] stored_chars [MAX_CHARS_DEF];
  int unsigned     stored_len;
  bit              chars_lost;
  rev_char_t       reversed_chars_q [$];
  rev_char_t       want;

  function automatic bit combining_mark(input logic [CP_W-1:0] cp);
    return ((cp >= MARK_A_LO) && (cp <= MARK_A_HI)) ||
           ((cp >= MARK_B_LO) && (cp <= MARK_B_HI)) ||
           ((cp >= MARK_C_LO) && (cp <= MARK_C_HI)) ||
           ((cp >= MARK_D_LO) && (cp <= MARK_D_HI));
  endfunction

  // walk clusters from the tail; marks stay behind their base
  task automatic reverse_by_clusters();
    int unsigned stop;
    int unsigned start;
    rev_char_t   item;
    stop = stored_len;
    while (stop > 0) begin
      start = stop - 1;
      while ((start > 0) && combining_mark(stored_chars[start]))
        start--;
      for (int unsigned k = start; k < stop; k++) begin
        item.cp   = stored_chars[k];
        item.fin  = (start == 0) && (k == stop - 1);
        item.lost = chars_lost;
        reversed_chars_q.push_back(item);
      end
      stop = start;
    end
    stored_len = 0;
    chars_lost = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_len       = 0;
      chars_lost       = 1'b0;
      mismatch_count_o = 0;
      reversed_chars_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (reversed_chars_q.size() == 0) begin
          $error("unexpected output transaction: code point %h", out_code_point_i);
          mismatch_count_o++;
        end else begin
          want = reversed_chars_q.pop_front();
          if (out_code_point_i !== want.cp) begin
            $error("out_code_point: expected %h, actual %h", want.cp, out_code_point_i);
            mismatch_count_o++;
          end
          if (out_last_i !== want.fin) begin
            $error("out_last: expected %b, actual %b", want.fin, out_last_i);
            mismatch_count_o++;
          end
          if (overflow_i !== want.lost) begin
            $error("overflow: expected %b, actual %b", want.lost, overflow_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (stored_len < MAX_CHARS_DEF) begin
          stored_chars[stored_len] = code_point_i;
          stored_len++;
        end else begin
          chars_lost = 1'b1;
        end
        if (last_char_i)
          reverse_by_clusters();
      end
    end
    pending_o = reversed_chars_q.size();
  end

endmodule

### sim/tb_combining_aware_string_reverse_top.sv
`timescale 1ns / 1ps

module tb_combining_aware_string_reverse_top;

  import csr_pkg::*;

  // clock, reset and everything driven into the block start at known values
  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_valid   = 1'b0;
  logic [CP_W-1:0] code_point = '0;
  logic            last_char  = 1'b0;
  logic            out_stall  = 1'b0;

  logic            in_stall;
  logic            out_valid;
  logic [CP_W-1:0] out_code_point;
  logic            out_last;
  logic            overflow;

  int unsigned     mismatch_count;
  int unsigned     pending;

  // idle and stall percentages of the current phase
  int unsigned     gap_pct   = 0;
  int unsigned     stall_pct = 0;

  // code points of the string being sent
  logic [CP_W-1:0] str_q [$];

  always #5 clk = ~clk;

  combining_aware_string_reverse_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .code_point_i     (code_point),
    .last_char_i      (last_char),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_code_point_o (out_code_point),
    .out_last_o       (out_last),
    .overflow_o       (overflow)
  );

  reversal_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .code_point_i     (code_point),
    .last_char_i      (last_char),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_code_point_i (out_code_point),
    .out_last_i       (out_last),
    .overflow_i       (overflow),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // receiver back-pressure, one fresh draw per cycle
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // mostly short plain text and marks, some full-range values and range edges
  function automatic logic [CP_W-1:0] random_char();
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    case ($urandom_range(3))
      0: begin
        lo = MARK_A_LO;
        hi = MARK_A_HI;
      end
      1: begin
        lo = MARK_B_LO;
        hi = MARK_B_HI;
      end
      2: begin
        lo = MARK_C_LO;
        hi = MARK_C_HI;
      end
      default: begin
        lo = MARK_D_LO;
        hi = MARK_D_HI;
      end
    endcase
    case ($urandom_range(9))
      0, 1, 2: return lo + CP_W'($urandom_range(hi - lo));
      3:       return CP_W'($urandom);
      4:       return $urandom_range(1) ? lo - 1'b1 : hi + 1'b1;
      5:       return $urandom_range(1) ? lo : hi;
      default: return CP_W'($urandom_range(32'h7E, 32'h20));
    endcase
  endfunction

  // one input transaction; an optional idle gap first, then hold until taken
  task automatic send_char(input logic [CP_W-1:0] cp, input logic fin);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid   <= 1'b1;
    code_point <= cp;
    last_char  <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_string();
    foreach (str_q[k])
      send_char(str_q[k], k == str_q.size() - 1);
  endtask

  // sender holds off until every predicted character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings
    // single character, code point zero as an ordinary base
    str_q = '{21'h000000};
    send_string();
    // all ones, above the Unicode range, stays a base
    str_q = '{21'h1FFFFF};
    send_string();
    // marks at the start join the first cluster; trailing marks stay with their base
    str_q = '{21'h000300, 21'h00036F, 21'h000041, 21'h001DC0, 21'h001DFF};
    send_string();
    // just outside each mark range: all bases
    str_q = '{21'h0002FF, 21'h000370, 21'h001DBF, 21'h001E00,
              21'h0020CF, 21'h002100, 21'h00FE1F, 21'h00FE30};
    send_string();
    // range ends of the other mark blocks behind one base, then a base beyond U+10FFFF
    str_q = '{21'h000061, 21'h0020D0, 21'h0020FF, 21'h00FE20, 21'h00FE2F, 21'h110000};
    send_string();
    // nothing but marks
    str_q = '{21'h00FE2F, 21'h000300};
    send_string();
    wait_drained();

    // random strings across the idle and stall phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 52;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 52;
        end
        default: begin
          gap_pct   = 24;
          stall_pct = 24;
        end
      endcase
      sent = 0;
      while (sent < 62) begin
        // open phases 1 to 3 with a full buffer (phase 2) or with overflow (phases 1 and 3)
        if (sent == 0 && ph == 1)
          len = 66;
        else if (sent == 0 && ph == 2)
          len = MAX_CHARS_DEF;
        else if (sent == 0 && ph == 3)
          len = 65;
        else if ($urandom_range(24) == 0)
          len = $urandom_range(68, 60);
        else
          len = $urandom_range(10, 1);
        str_q.delete();
        repeat (len)
          str_q.push_back(random_char());
        send_string();
        sent += len;
      end
      wait_drained();
    end

    // let any stray output show up before the verdict
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_combining_aware_string_reverse_top OK");
    end else begin
      $display("tb_combining_aware_string_reverse_top NOT OK");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #2000000;
    $display("tb_combining_aware_string_reverse_top NOT OK");
    $finish;
  end

endmodule
